/* rtl/aos_pkg.sv */
// shared types and constants of the letter order sorter
package aos_pkg;

  localparam int ALPHA     = 26;
  localparam int MAX_LEN   = 64;
  localparam int LETTER_W  = 5;
  localparam int POS_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(ALPHA + 1);

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PREFIX = 2'd1,
    ST_CYCLE  = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_VISIT,
    S_CHECK,
    S_EMIT,
    S_FAIL,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic    add;
    letter_t from;
    letter_t to;
    logic    seen;
    letter_t letter;
    logic    start;
    status_t err;
  } req_t;

endpackage

/* rtl/aos_ram.sv */
// generic single write, single registered read ram
module aos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/aos_sort.sv */
// precedence graph store and kahn sort sequencer with result register
module aos_sort (
  input  logic              clk,
  input  logic              rst,
  input  aos_pkg::req_t     req,
  output logic              busy,
  output logic              result_valid,
  input  logic              result_ready,
  output aos_pkg::letter_t  out_letter,
  output logic [1:0]        status,
  output logic              last
);
  import aos_pkg::*;

  state_t          state, state_next;
  logic [ALPHA-1:0] seen;
  logic [ALPHA-1:0] edges [ALPHA];
  letter_t         indeg [ALPHA];
  letter_t         queue [ALPHA];
  cnt_t            head, tail, seen_cnt;
  letter_t         idx, u;
  status_t         err;
  logic            out_free;
  logic            emit;
  logic            idx_end;
  letter_t         dec;

  assign out_free = !result_valid || result_ready;
  assign emit     = out_free && (state == S_EMIT || state == S_FAIL);
  assign idx_end  = (idx == letter_t'(ALPHA - 1));
  assign busy     = (state != S_IDLE);
  assign dec      = indeg[idx] - letter_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.start) begin
          state_next = (req.err == ST_OK) ? S_SCAN : S_FAIL;
        end
      end
      S_SCAN: begin
        if (idx_end) begin
          state_next = S_CHECK;
          if (head != tail || (seen[idx] && indeg[idx] == '0)) begin
            state_next = S_POP;
          end
        end
      end
      S_POP:   state_next = S_VISIT;
      S_VISIT: begin
        if (idx_end) begin
          state_next = S_CHECK;
          if (head != tail || (edges[u][idx] && dec == '0 && tail < cnt_t'(ALPHA))) begin
            state_next = S_POP;
          end
        end
      end
      S_CHECK: begin
        state_next = (tail < seen_cnt || tail == '0) ? S_FAIL : S_EMIT;
      end
      S_EMIT: begin
        if (out_free && cnt_t'(idx) + cnt_t'(1) == tail) begin
          state_next = S_CLEAR;
        end
      end
      S_FAIL: begin
        if (out_free) begin
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen         <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < ALPHA; i++) begin
        edges[i] <= '0;
        indeg[i] <= '0;
      end
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.add && !edges[req.from][req.to]) begin
            edges[req.from][req.to] <= 1'b1;
            indeg[req.to]           <= indeg[req.to] + letter_t'(1);
          end
          if (req.seen) begin
            seen[req.letter] <= 1'b1;
          end
          if (req.start) begin
            err      <= req.err;
            idx      <= '0;
            head     <= '0;
            tail     <= '0;
            seen_cnt <= '0;
          end
        end
        S_SCAN: begin
          if (seen[idx]) begin
            seen_cnt <= seen_cnt + cnt_t'(1);
            if (indeg[idx] == '0) begin
              queue[tail[LETTER_W-1:0]] <= idx;
              tail <= tail + cnt_t'(1);
            end
          end
          idx <= idx_end ? '0 : idx + letter_t'(1);
        end
        S_POP: begin
          u    <= queue[head[LETTER_W-1:0]];
          head <= head + cnt_t'(1);
          idx  <= '0;
        end
        S_VISIT: begin
          if (edges[u][idx]) begin
            indeg[idx] <= dec;
            if (dec == '0 && tail < cnt_t'(ALPHA)) begin
              queue[tail[LETTER_W-1:0]] <= idx;
              tail <= tail + cnt_t'(1);
            end
          end
          idx <= idx_end ? '0 : idx + letter_t'(1);
        end
        S_CHECK: begin
          idx <= '0;
          err <= ST_CYCLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_letter   <= queue[idx];
            status       <= ST_OK;
            last         <= (cnt_t'(idx) + cnt_t'(1) == tail);
            idx          <= idx + letter_t'(1);
          end
        end
        S_FAIL: begin
          if (out_free) begin
            out_letter   <= '0;
            status       <= err;
            last         <= 1'b1;
          end
        end
        S_CLEAR: begin
          seen <= '0;
          for (int i = 0; i < ALPHA; i++) begin
            edges[i] <= '0;
            indeg[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/alien_order_topological_sort_core.sv */
// Letters load at one per cycle while the sorter is idle; each word is
// compared against the previous word kept in a 64-entry ram and the first
// differing letter adds a precedence edge. After the item flagged list_end
// the block is not ready while a single sequencer runs kahn's sort or reports
// an error (a scan of 26 letters seeds the queue, one neighbour test a cycle
// per queued letter, one result a cycle unless stalled), then clears the graph.
module alien_order_topological_sort_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  aos_pkg::letter_t letter,
  input  logic             word_end,
  input  logic             list_end,
  output logic             result_valid,
  input  logic             result_ready,
  output aos_pkg::letter_t out_letter,
  output logic [1:0]       status,
  output logic             last
);
  import aos_pkg::*;

  logic [POS_W-1:0]  position, prev_len, pos_inc;
  logic              first_word, still;
  status_t           err, err_new;
  logic              accept, over, wend, cmp, sm_mid, prefix_err, busy;
  letter_t           letter_s, rd_data;
  logic [ADDR_W-1:0] raddr;
  req_t              req;

  assign accept     = item_valid && item_ready;
  assign item_ready = !busy;
  assign letter_s   = (letter >= letter_t'(ALPHA)) ? letter_t'(ALPHA - 1) : letter;
  assign over       = (position >= POS_W'(MAX_LEN));
  assign wend       = word_end || list_end;
  assign pos_inc    = over ? position : position + POS_W'(1);
  assign cmp        = !over && !first_word && still;

  always_comb begin
    sm_mid = still;
    if (cmp && (position >= prev_len || rd_data != letter_s)) begin
      sm_mid = 1'b0;
    end
    prefix_err = wend && !first_word && sm_mid && (pos_inc < prev_len);
    err_new = err;
    if (err == ST_OK) begin
      if (over) begin
        err_new = ST_LONG;
      end else if (prefix_err) begin
        err_new = ST_PREFIX;
      end
    end
  end

  always_comb begin
    req.add    = accept && cmp && position < prev_len && rd_data != letter_s;
    req.from   = rd_data;
    req.to     = letter_s;
    req.seen   = accept;
    req.letter = letter_s;
    req.start  = accept && list_end;
    req.err    = err_new;
  end

  assign raddr = accept ? (wend ? '0 : pos_inc[ADDR_W-1:0]) : position[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      prev_len   <= '0;
      first_word <= 1'b1;
      still      <= 1'b1;
      err        <= ST_OK;
    end else if (accept) begin
      if (list_end) begin
        position   <= '0;
        prev_len   <= '0;
        first_word <= 1'b1;
        still      <= 1'b1;
        err        <= ST_OK;
      end else if (wend) begin
        prev_len   <= pos_inc;
        position   <= '0;
        first_word <= 1'b0;
        still      <= 1'b1;
        err        <= err_new;
      end else begin
        position <= pos_inc;
        still    <= sm_mid;
        err      <= err_new;
      end
    end
  end

  aos_ram #(
    .WIDTH(LETTER_W),
    .DEPTH(MAX_LEN)
  ) u_prev_word (
    .clk   (clk),
    .we    (accept && !over),
    .waddr (position[ADDR_W-1:0]),
    .wdata (letter_s),
    .raddr (raddr),
    .rdata (rd_data)
  );

  aos_sort u_sort (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .busy         (busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_letter   (out_letter),
    .status       (status),
    .last         (last)
  );

endmodule

/* dv/alien_order_topological_sort_checker.sv */
// checker for the letter order sorter: predicts the order and compares results
`timescale 1ns / 1ps
module alien_order_topological_sort_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  aos_pkg::letter_t letter,
  input  logic             word_end,
  input  logic             list_end,
  input  logic             result_valid,
  input  logic             result_ready,
  input  aos_pkg::letter_t out_letter,
  input  logic [1:0]       status,
  input  logic             last,
  output int               fail_count,
  output int               pending
);
  import aos_pkg::*;

  typedef struct packed {
    letter_t l;
    status_t st;
    logic    lst;
  } order_entry_t;

  order_entry_t order_q[$];

  letter_t     prev_word [MAX_LEN];
  int          prev_len, pos;
  bit          first_word, matching;
  status_t     err;
  logic [25:0] seen;
  logic [25:0] precedes [ALPHA];
  logic [4:0]  indeg [ALPHA];

  function automatic void add_expected(letter_t l, status_t st, logic lst);
    order_entry_t e;
    e.l = l;
    e.st = st;
    e.lst = lst;
    order_q.insert(order_q.size(), e);
  endfunction

  task automatic clear_graph();
    prev_len = 0; pos = 0; first_word = 1; matching = 1; err = ST_OK; seen = '0;
    for (int i = 0; i < ALPHA; i++) begin
      precedes[i] = '0;
      indeg[i] = '0;
    end
  endtask

  task automatic sort_letters();
    letter_t q [ALPHA];
    int head, tail, cnt;
    letter_t u;
    head = 0; tail = 0; cnt = 0;
    for (int i = 0; i < ALPHA; i++)
      if (seen[i]) begin
        cnt++;
        if (indeg[i] == 0) begin
          q[tail] = letter_t'(i);
          tail++;
        end
      end
    while (head < tail) begin
      u = q[head];
      head++;
      for (int v = 0; v < ALPHA; v++)
        if (precedes[u][v]) begin
          indeg[v] = indeg[v] - 5'd1;
          if (indeg[v] == 0 && tail < ALPHA) begin
            q[tail] = letter_t'(v);
            tail++;
          end
        end
    end
    if (tail < cnt || tail == 0)
      add_expected('0, ST_CYCLE, 1'b1);
    else
      for (int i = 0; i < tail; i++)
        add_expected(q[i], ST_OK, i + 1 == tail);
  endtask

  task automatic take_letter(letter_t li, logic we, logic le);
    letter_t c, p;
    c = (li >= ALPHA) ? letter_t'(ALPHA - 1) : li;
    seen[c] = 1'b1;
    if (pos >= MAX_LEN) begin
      if (err == ST_OK) err = ST_LONG;
    end else begin
      if (!first_word && matching) begin
        if (pos < prev_len) begin
          p = prev_word[pos];
          if (p != c) begin
            if (!precedes[p][c]) begin
              precedes[p][c] = 1'b1;
              indeg[c] = indeg[c] + 5'd1;
            end
            matching = 0;
          end
        end else matching = 0;
      end
      prev_word[pos] = c;
      pos++;
    end
    if (we || le) begin
      if (!first_word && matching && pos < prev_len && err == ST_OK) err = ST_PREFIX;
      prev_len = pos; pos = 0; first_word = 0; matching = 1;
    end
    if (le) begin
      if (err != ST_OK) add_expected('0, err, 1'b1);
      else sort_letters();
      clear_graph();
    end
  endtask

  always @(posedge clk) begin
    order_entry_t e;
    if (rst) begin
      fail_count = 0;
      clear_graph();
    end else begin
      if (result_valid && result_ready) begin
        if (order_q.size() == 0) begin
          $display("%0t: unexpected result letter %0d status %0d last %0d",
                   $time, out_letter, status, last);
          fail_count++;
        end else begin
          e = order_q.pop_front();
          if (out_letter !== e.l || status !== e.st || last !== e.lst) begin
            $display("%0t: expected letter %0d status %0d last %0d, got %0d %0d %0d",
                     $time, e.l, e.st, e.lst, out_letter, status, last);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) take_letter(letter, word_end, list_end);
    end
    pending = order_q.size();
  end
endmodule

/* dv/alien_order_topological_sort_core_test.sv */
// top of the letter order sorter testbench: stimulus, idling and verdict
`timescale 1ns / 1ps
module alien_order_topological_sort_core_test;
  import aos_pkg::*;

  logic clk, rst;
  logic item_valid, item_ready, word_end, list_end;
  letter_t letter;
  logic result_valid, result_ready, last;
  letter_t out_letter;
  logic [1:0] status;
  int fail_count, pending;
  int send_idle, recv_stall;

  alien_order_topological_sort_core dut (.*);
  alien_order_topological_sort_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk)
    result_ready <= ($urandom_range(99) >= recv_stall);

  task automatic send(letter_t l, logic we, logic le);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1; letter <= l; word_end <= we; list_end <= le;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic send_word(letter_t w[$], logic le);
    for (int i = 0; i < w.size(); i++)
      send(w[i], i == w.size() - 1, le && i == w.size() - 1);
  endtask

  // random sorted-ish list over an alphabet of 2 to 26 letters, sometimes broken
  task automatic random_list();
    letter_t w[$], pw[$];
    int nw, span, keep;
    nw = $urandom_range(6, 1);
    span = $urandom_range(26, 2);
    pw = {};
    for (int k = 0; k < nw; k++) begin
      w = {};
      if (pw.size() > 0 && $urandom_range(3) != 0) begin
        keep = $urandom_range(pw.size());
        for (int i = 0; i < keep; i++) w.insert(w.size(), pw[i]);
      end
      repeat ($urandom_range(3, w.size() == 0 ? 1 : 0))
        w.insert(w.size(), ($urandom_range(15) == 0) ? letter_t'($urandom_range(31))
                                                     : letter_t'($urandom_range(span - 1)));
      if (w.size() == 0) w.insert(w.size(), letter_t'($urandom_range(25)));
      send_word(w, k == nw - 1);
      pw = w;
    end
  endtask

  initial begin
    letter_t w[$];
    rst = 1; item_valid = 0; letter = 0; word_end = 0; list_end = 0;
    result_ready = 0; send_idle = 0; recv_stall = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed: plain order, prefix conflict, cycle, equal words, letter 31, long word
    send_word('{5'd0, 5'd1}, 0); send_word('{5'd0, 5'd2}, 0); send_word('{5'd25}, 1);
    send_word('{5'd0, 5'd1}, 0); send_word('{5'd0}, 1);
    send_word('{5'd0}, 0); send_word('{5'd1}, 0); send_word('{5'd0}, 1);
    send_word('{5'd3, 5'd4}, 0); send_word('{5'd3, 5'd4}, 1);
    send(5'd31, 0, 0); send(5'd16, 1, 1);
    w = {};
    repeat (66) w.insert(w.size(), letter_t'($urandom_range(25)));
    send_word(w, 1);
    item_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 28 : 47) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 28 : 47) : 0;
      repeat (2) random_list();
    end
    item_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
